// ----- rtl/core/lnasm_pkg.sv -----
// Shared constants and types for the line assembler.
// No dependencies; imported by line_assembler_with_overflow_modes.
package lnasm_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EOF   = 3'd1;
  localparam logic [2:0] ST_ERROR = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_WAIT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SINGLE,
    ACT_RUN
  } action_t;

endpackage

// ----- rtl/core/line_assembler_with_overflow_modes.sv -----
// Line assembler: collects stream bytes into a line store and emits lines.
// Depends on lnasm_pkg for capacity, character and status constants.
//
// One input item is taken per cycle while no result is being produced. An
// item that yields a single result (status report or empty chunk) waits for
// its output load; a line is read back from the line store one character at
// a time, each through a memory read step and then an output load step, and
// the next item is accepted once the last one is loaded. A stalled output
// stretches each output load. The line store needs no clearing after reset.
module line_assembler_with_overflow_modes (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic [2:0] read_status,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line_char,
  output logic       no_char,
  output logic       last_of_line,
  output logic [2:0] line_status
);
  import lnasm_pkg::*;

  logic [7:0]        line_store [LINE_CAPACITY];
  logic [7:0]        rd_data;

  state_t            state, state_next;
  logic              overflow_mode;
  logic [CNT_W-1:0]  fill_count;
  logic              previous_complete;
  logic              discarding;
  logic [ADDR_W-1:0] emit_idx;
  logic [ADDR_W-1:0] emit_end;
  logic [2:0]        pend_status;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              run_last;

  action_t           act;
  logic [2:0]        act_status;
  logic [ADDR_W-1:0] act_end;
  logic [CNT_W-1:0]  fill_next;
  logic              pc_next;
  logic              disc_next;
  logic              wr_en;

  logic [2:0]        status_n;
  logic              is_break;
  logic              pc_eff;
  logic [CNT_W-1:0]  fill_inc;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign run_last = (emit_idx == emit_end);

  // Decide what the incoming item does to the line state.
  always_comb begin
    status_n   = (read_status > ST_LAST) ? ST_ERROR : read_status;
    is_break   = (data_byte == CH_CR) || (data_byte == CH_LF);
    pc_eff     = ((fill_count == '0) && overflow_mode) ? 1'b1 : previous_complete;
    fill_inc   = fill_count + CNT_W'(1);
    act        = ACT_NONE;
    act_status = ST_OK;
    act_end    = '0;
    fill_next  = fill_count;
    pc_next    = previous_complete;
    disc_next  = discarding;
    wr_en      = 1'b0;
    if (discarding) begin
      if (!(status_n == ST_OK && !is_break)) begin
        act       = ACT_RUN;
        act_end   = ADDR_W'(LINE_CAPACITY - 2);
        fill_next = '0;
        disc_next = 1'b0;
      end
    end else begin
      pc_next = pc_eff;
      if (status_n >= ST_ERROR) begin
        fill_next  = '0;
        act        = ACT_SINGLE;
        act_status = status_n;
      end else if (status_n == ST_EOF || is_break) begin
        if (fill_count == '0 && pc_eff) begin
          if (status_n == ST_EOF) begin
            act        = ACT_SINGLE;
            act_status = ST_EOF;
          end
        end else begin
          pc_next   = 1'b1;
          fill_next = '0;
          if (fill_count == '0) begin
            // Line end right after a split chunk: one empty chunk.
            act        = ACT_SINGLE;
            act_status = ST_OK;
          end else begin
            act     = ACT_RUN;
            act_end = ADDR_W'(fill_count - CNT_W'(1));
          end
        end
      end else begin
        wr_en     = 1'b1;
        fill_next = fill_inc;
        if (fill_inc == CNT_W'(LINE_CAPACITY)) begin
          pc_next = 1'b0;
          if (overflow_mode) begin
            disc_next = 1'b1;
          end else begin
            act       = ACT_RUN;
            act_end   = ADDR_W'(LINE_CAPACITY - 1);
            fill_next = '0;
          end
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (act)
            ACT_SINGLE: state_next = S_SINGLE;
            ACT_RUN:    state_next = S_WAIT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SINGLE: begin
        if (out_free) state_next = S_IDLE;
      end
      S_WAIT: state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = run_last ? S_IDLE : S_WAIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_SINGLE: out_load = out_free;
      S_OUT:    out_load = out_free;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      overflow_mode     <= 1'b0;
      fill_count        <= '0;
      previous_complete <= 1'b1;
      discarding        <= 1'b0;
      out_valid         <= 1'b0;
      emit_idx          <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) overflow_mode <= cfg_wdata;
      if (accept) begin
        fill_count        <= fill_next;
        previous_complete <= pc_next;
        discarding        <= disc_next;
        emit_idx          <= '0;
      end else if (state == S_OUT && out_load && !run_last) begin
        emit_idx <= emit_idx + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emit_end    <= act_end;
      pend_status <= act_status;
    end
    if (out_load) begin
      if (state == S_OUT) begin
        line_char    <= rd_data;
        no_char      <= 1'b0;
        last_of_line <= run_last;
        line_status  <= ST_OK;
      end else begin
        line_char    <= 8'h00;
        no_char      <= 1'b1;
        last_of_line <= 1'b1;
        line_status  <= pend_status;
      end
    end
  end

  // Line store: written while assembling, read back while emitting.
  always_ff @(posedge clk) begin
    if (accept && wr_en) line_store[fill_count[ADDR_W-1:0]] <= data_byte;
    rd_data <= line_store[emit_idx];
  end

`ifndef NO_ASSERTIONS
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (accept && !discarding) |-> (fill_count < CNT_W'(LINE_CAPACITY)))
    else $error("fill count reached capacity outside a discard");

  a_discard_full: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (fill_count == CNT_W'(LINE_CAPACITY)))
    else $error("discarding without a full line store");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_load && run_last) |=> (state == S_IDLE && last_of_line))
    else $error("last character of a line did not end the run");

  a_run_chars: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_load) |=> (!no_char && line_status == ST_OK))
    else $error("line character item carries a status");
`endif

endmodule

// ----- tb/tb_line_assembler_with_overflow_modes.sv -----
// Testbench for the line assembler: random and directed byte streams are checked
// against a behavioral predictor of line splitting, truncation and status reports.
// Depends on lnasm_pkg and line_assembler_with_overflow_modes.
module tb_line_assembler_with_overflow_modes;
  import lnasm_pkg::*;

  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = ST_LAST;
  localparam logic       MODE_SPLIT = 1'b0;
  localparam logic       MODE_TRUNC = 1'b1;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] st;
  } stream_ev_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       nc;
    logic       last;
    logic [2:0] st;
  } line_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic [2:0] read_status = 3'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] line_char;
  logic       no_char;
  logic       last_of_line;
  logic [2:0] line_status;

  stream_ev_t stream_q[$];
  line_item_t line_items_due[$];
  int         mismatch_cnt = 0;
  int         queued = 0;
  bit         idle_en = 1'b1;
  int         freeze_cycles = 0;
  int         send_gap = 0;
  int         ready_gap = 0;

  // Predictor state.
  logic [7:0] line_buf [LINE_CAPACITY];
  int         fill_cnt;
  bit         prev_done;
  bit         dropping;
  logic       cut_mode;

  line_assembler_with_overflow_modes i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .read_status  (read_status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_char    (line_char),
    .no_char      (no_char),
    .last_of_line (last_of_line),
    .line_status  (line_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!idle_en || r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_cnt < 40)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic void queue_run(int n);
    if (n == 0) begin
      line_items_due.push_back('{8'h00, 1'b1, 1'b1, ST_OK});
      return;
    end
    for (int i = 0; i < n; i++)
      line_items_due.push_back('{line_buf[i], 1'b0, (i == n - 1), ST_OK});
  endfunction

  // Works out the items that one accepted stream event produces.
  function automatic void assemble_line(logic [7:0] c, logic [2:0] rs);
    logic [2:0] st;
    bit         ends;
    st = (rs > ST_LAST) ? ST_ERROR : rs;
    if (dropping) begin
      if (st == ST_OK && c != CH_CR && c != CH_LF) return;
      queue_run(LINE_CAPACITY - 1);
      fill_cnt = 0;
      dropping = 1'b0;
      return;
    end
    if (fill_cnt == 0 && cut_mode == MODE_TRUNC) prev_done = 1'b1;
    if (st >= ST_ERROR) begin
      fill_cnt = 0;
      line_items_due.push_back('{8'h00, 1'b1, 1'b1, st});
      return;
    end
    ends = (st == ST_EOF) || c == CH_CR || c == CH_LF;
    if (ends) begin
      if (fill_cnt == 0 && prev_done) begin
        if (st == ST_EOF) line_items_due.push_back('{8'h00, 1'b1, 1'b1, ST_EOF});
        return;
      end
      prev_done = 1'b1;
      queue_run(fill_cnt);
      fill_cnt = 0;
      return;
    end
    line_buf[fill_cnt] = c;
    fill_cnt++;
    if (fill_cnt < LINE_CAPACITY) return;
    prev_done = 1'b0;
    if (cut_mode == MODE_TRUNC) begin
      dropping = 1'b1;
      return;
    end
    queue_run(LINE_CAPACITY);
    fill_cnt = 0;
  endfunction

  // Driver: presents queued stream events, holding each until it is taken.
  always @(posedge clk) begin : drive_in
    stream_ev_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (stream_q.size() != 0) begin
        nxt = stream_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= nxt.ch;
        read_status <= nxt.st;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_gap = 0;
    end else if (freeze_cycles > 0) begin
      out_ready <= 1'b0;
      freeze_cycles--;
    end else if (ready_gap > 0) begin
      out_ready <= 1'b0;
      ready_gap--;
    end else begin
      out_ready <= 1'b1;
      ready_gap = pick_gap();
    end
  end

  // Monitor: tracks register writes and accepted events, checks every result.
  always @(posedge clk) begin : watch
    line_item_t want;
    if (rst) begin
      fill_cnt = 0;
      prev_done = 1'b1;
      dropping = 1'b0;
      cut_mode = MODE_SPLIT;
      for (int i = 0; i < LINE_CAPACITY; i++) line_buf[i] = 8'h00;
    end else begin
      // An item taken at this edge still sees the mode from before the write.
      if (in_valid && in_ready) assemble_line(data_byte, read_status);
      if (cfg_we) cut_mode = cfg_wdata;
      if (out_valid && out_ready) begin
        if (line_items_due.size() == 0) begin
          flag_mismatch("item with nothing due", line_char, 8'h00);
        end else begin
          want = line_items_due.pop_front();
          if (line_char !== want.ch) flag_mismatch("line_char", line_char, want.ch);
          if (no_char !== want.nc)
            flag_mismatch("no_char", 8'(no_char), 8'(want.nc));
          if (last_of_line !== want.last)
            flag_mismatch("last_of_line", 8'(last_of_line), 8'(want.last));
          if (line_status !== want.st)
            flag_mismatch("line_status", 8'(line_status), 8'(want.st));
        end
      end
    end
  end

  task automatic add_item(logic [7:0] c, logic [2:0] s);
    stream_q.push_back('{c, s});
    queued++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  task automatic add_text(int n);
    for (int i = 0; i < n; i++) add_item(text_byte(), ST_OK);
  endtask

  // A line of random text with a random ending; a little noise is mixed in.
  task automatic add_random_line();
    int len;
    int r;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(12);
    else if (r < 82) len = $urandom_range(66, 60);
    else if (r < 90) len = $urandom_range(40, 13);
    else len = $urandom_range(132, 120);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 2) add_item(8'($urandom), 3'($urandom_range(7, 2)));
      else if (r < 4) add_item(8'($urandom), ST_OK);
      else add_item(text_byte(), ST_OK);
    end
    r = $urandom_range(99);
    if (r < 40) begin
      add_item(CH_LF, ST_OK);
    end else if (r < 70) begin
      add_item(CH_CR, ST_OK);
    end else if (r < 80) begin
      add_item(CH_CR, ST_OK);
      add_item(CH_LF, ST_OK);
    end else if (r < 90) begin
      add_item(8'($urandom), ST_EOF);
    end else begin
      add_item(8'($urandom), 3'($urandom_range(7, 2)));
    end
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every event is taken and every due item has come out.
  task automatic drain();
    do @(negedge clk);
    while (stream_q.size() != 0 || in_valid || line_items_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_mode(MODE_SPLIT);

    // Directed events in split mode.
    add_item(8'h00, ST_EOF);
    add_item(CH_LF, ST_OK);
    add_item(CH_CR, ST_OK);
    add_item(8'h00, ST_OK);
    add_item(8'hFF, ST_OK);
    add_item(8'h80, ST_OK);
    add_item(8'h7F, ST_OK);
    add_item(CH_CR, ST_OK);
    add_item(8'h41, ST_OK);
    add_item(8'h42, ST_EOF);
    add_item(8'h43, ST_OK);
    add_item(8'h55, ST_ERROR);
    add_item(CH_LF, ST_RANGE);
    add_item(8'h00, ST_TIMEOUT);
    add_item(8'hFF, 3'd5);
    add_item(CH_CR, 3'd6);
    add_item(CH_LF, 3'd7);
    add_item(8'h44, ST_OK);
    add_item(8'h45, ST_OK);
    add_item(CH_LF, ST_OK);
    drain();

    // Directed events in truncate mode.
    write_mode(MODE_TRUNC);
    add_item(8'h46, ST_OK);
    add_item(CH_CR, ST_OK);
    add_item(8'h47, ST_OK);
    add_item(8'h00, ST_TIMEOUT);
    add_item(8'hFF, ST_EOF);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_en = (ph != 2);
      write_mode((ph % 2 == 1) ? MODE_TRUNC : MODE_SPLIT);
      // A lone line end first: it closes a discard left over from the last phase,
      // or is skipped after a split chunk since truncate mode starts a fresh line.
      add_item(CH_LF, ST_OK);
      if (ph == 3) freeze_cycles = 800;
      if (ph == 0) begin
        // A full chunk followed directly by a line end gives an empty chunk.
        add_text(LINE_CAPACITY);
        add_item(CH_CR, ST_OK);
      end
      start = queued;
      while (queued - start < PHASE_ITEMS) add_random_line();
      // Leave the line open across the mode switch.
      if (ph < 2)
        add_text((ph % 2 == 0) ? LINE_CAPACITY : LINE_CAPACITY + 3);
      drain();
    end

    if (line_items_due.size() != 0)
      flag_mismatch("items never produced", 8'(line_items_due.size()), 8'h00);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- line_assembler_with_overflow_modes.f -----
rtl/core/lnasm_pkg.sv
rtl/core/line_assembler_with_overflow_modes.sv
tb/tb_line_assembler_with_overflow_modes.sv
